// ===== rtl/rmq_pkg.sv =====
// Package for the rotation matrix to quaternion block.
// Holds default widths, the queue depth, branch codes and the control bundle.
// No dependencies.
package rmq_pkg;

  localparam int FRAC_BITS_DEF   = 14;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    BR_W = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } branch_e;

  typedef struct packed {
    branch_e branch;
    logic    bad;
  } rmq_ctl_t;

endpackage

// ===== rtl/rmq_in_if.sv =====
// Input channel of the rotation matrix to quaternion block: nine matrix elements.
// Depends on nothing but its width parameter.
interface rmq_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] m00, m01, m02;
  logic signed [W-1:0] m10, m11, m12;
  logic signed [W-1:0] m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

// ===== rtl/rmq_out_if.sv =====
// Output channel of the rotation matrix to quaternion block: one quaternion.
// Depends on nothing but its width parameter.
interface rmq_out_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] qw, qx, qy, qz;
  logic [1:0]          root_branch;
  logic                not_rotation;

  modport source (output valid, qw, qx, qy, qz, root_branch, not_rotation,
                  input ready);
  modport sink   (input valid, qw, qx, qy, qz, root_branch, not_rotation,
                  output ready);
endinterface

// ===== rtl/rmq_front.sv =====
// Front end: accepts a matrix, picks the branch, forms the radicand and numerators.
// Depends on rmq_pkg and rmq_in_if.
module rmq_front #(
  parameter int W = rmq_pkg::VALUE_WIDTH_DEF,
  parameter int F = rmq_pkg::FRAC_BITS_DEF,
  parameter int IW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rmq_in_if.sink        in_i,
  output logic          item_valid_o,
  input  logic          item_ready_i,
  output logic [IW-1:0] item_o
);
  import rmq_pkg::*;

  localparam int RadW = ((W + 2 > F + 1) ? W + 2 : F + 1) + 1;
  localparam int MagW = RadW - 1;

  logic signed [RadW-1:0] e00, e11, e22, tr, rad, one;
  logic signed [W:0]      n0, n1, n2;
  rmq_ctl_t               ctl;
  logic                   v_q;
  logic [IW-1:0]          item_q;

  assign e00 = RadW'(in_i.m00);
  assign e11 = RadW'(in_i.m11);
  assign e22 = RadW'(in_i.m22);
  assign one = RadW'(1) << F;
  assign tr  = e00 + e11 + e22;

  always_comb begin
    if (tr > 0) begin
      ctl.branch = BR_W;
      rad = tr + one;
      n0  = (W+1)'(in_i.m21) - (W+1)'(in_i.m12);
      n1  = (W+1)'(in_i.m20) - (W+1)'(in_i.m02);
      n2  = (W+1)'(in_i.m10) - (W+1)'(in_i.m01);
    end else if (in_i.m22 > in_i.m11 && in_i.m22 > in_i.m00) begin
      ctl.branch = BR_Z;
      rad = e22 - e11 - e00 + one;
      n0  = (W+1)'(in_i.m10) - (W+1)'(in_i.m01);
      n1  = (W+1)'(in_i.m20) + (W+1)'(in_i.m02);
      n2  = (W+1)'(in_i.m21) + (W+1)'(in_i.m12);
    end else if (in_i.m11 > in_i.m00) begin
      ctl.branch = BR_Y;
      rad = e11 - e22 - e00 + one;
      n0  = (W+1)'(in_i.m20) - (W+1)'(in_i.m02);
      n1  = (W+1)'(in_i.m10) + (W+1)'(in_i.m01);
      n2  = (W+1)'(in_i.m21) + (W+1)'(in_i.m12);
    end else begin
      ctl.branch = BR_X;
      rad = e00 - e11 - e22 + one;
      n0  = (W+1)'(in_i.m21) - (W+1)'(in_i.m12);
      n1  = (W+1)'(in_i.m01) + (W+1)'(in_i.m10);
      n2  = (W+1)'(in_i.m20) + (W+1)'(in_i.m02);
    end
    ctl.bad = (rad <= 0);
  end

  assign in_i.ready   = !v_q || item_ready_i;
  assign item_valid_o = v_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_i.ready) begin
      v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= {rad[MagW-1:0], n0, n1, n2, ctl};
    end
  end

endmodule

// ===== rtl/rmq_fifo.sv =====
// Short queue between the front end and the arithmetic pipeline.
// Depends on rmq_pkg for the default depth.
module rmq_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = rmq_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import rmq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_pop_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue count did not drop on pop");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wr_q == rd_q)
    else $error("empty queue with split pointers");

endmodule

// ===== rtl/rmq_back.sv =====
// Back end: pipelined square root, three pipelined dividers, rounding and output register.
// Depends on rmq_pkg and rmq_out_if.
module rmq_back #(
  parameter int W = rmq_pkg::VALUE_WIDTH_DEF,
  parameter int F = rmq_pkg::FRAC_BITS_DEF,
  parameter int IW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  output logic          item_ready_o,
  input  logic [IW-1:0] item_i,
  rmq_out_if.source     out_o
);
  import rmq_pkg::*;

  localparam int RadW = ((W + 2 > F + 1) ? W + 2 : F + 1) + 1;
  localparam int MagW = RadW - 1;
  localparam int N    = MagW + F;
  localparam int SW   = (N + 1) / 2;
  localparam int DW   = W + 1 + F;
  localparam int DenW = SW + 1;
  localparam int CtlW = $bits(rmq_ctl_t);
  localparam int PW   = 3 * (W + 1) + CtlW;

  logic en;
  logic out_v_q;

  assign en           = !out_v_q || out_o.ready;
  assign item_ready_o = en;

  // Square root, one result bit per stage.
  logic [2*SW-1:0] sq_x [0:SW];
  logic [SW:0]     sq_r [0:SW];
  logic [SW-1:0]   sq_s [0:SW];
  logic [PW-1:0]   sq_p [0:SW];
  logic            sq_v [0:SW];

  assign sq_x[0] = (2*SW)'({item_i[IW-1 -: MagW], {F{1'b0}}});
  assign sq_r[0] = '0;
  assign sq_s[0] = '0;
  assign sq_p[0] = item_i[PW-1:0];
  assign sq_v[0] = item_valid_i;

  for (genvar k = 0; k < SW; k++) begin : g_sq
    logic [SW+2:0] trial, cand;
    logic          ge;
    assign trial = {sq_r[k], sq_x[k][2*SW-1 -: 2]};
    assign cand  = {1'b0, sq_s[k], 2'b01};
    assign ge    = (trial >= cand);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_x[k+1] <= sq_x[k] << 2;
        sq_r[k+1] <= ge ? (SW+1)'(trial - cand) : trial[SW:0];
        sq_s[k+1] <= (SW > 1) ? {sq_s[k][SW-2:0], ge} : SW'(ge);
        sq_p[k+1] <= sq_p[k];
      end
    end
  end

  // Dividers: each lane forms |n| * 2^F / (2S), one quotient bit per stage.
  logic [DW-1:0]   dv_x [0:2][0:DW];
  logic [DenW-1:0] dv_r [0:2][0:DW];
  logic [DW-1:0]   dv_q [0:2][0:DW];
  logic [DenW-1:0] dv_den [0:DW];
  logic [SW-1:0]   dv_h [0:DW];
  logic [PW-1:0]   dv_p [0:DW];
  logic            dv_v [0:DW];
  logic [SW:0]     root_sum;

  assign root_sum  = {1'b0, sq_s[SW]} + 1'b1;
  assign dv_den[0] = {sq_s[SW], 1'b0};
  assign dv_h[0]   = root_sum[SW:1];
  assign dv_p[0]   = sq_p[SW];
  assign dv_v[0]   = sq_v[SW];

  for (genvar l = 0; l < 3; l++) begin : g_lane_in
    logic signed [W:0] n;
    logic [W:0]        mag;
    assign n   = sq_p[SW][CtlW + (2 - l) * (W + 1) +: W + 1];
    assign mag = n[W] ? (W+1)'(0) - n : n;
    assign dv_x[l][0] = {mag, {F{1'b0}}};
    assign dv_r[l][0] = '0;
    assign dv_q[l][0] = '0;
  end

  for (genvar j = 0; j < DW; j++) begin : g_dv
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_den[j+1] <= dv_den[j];
        dv_h[j+1]   <= dv_h[j];
        dv_p[j+1]   <= dv_p[j];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DenW:0] t;
      logic          ge;
      assign t  = {dv_r[l][j], dv_x[l][j][DW-1]};
      assign ge = (t >= {1'b0, dv_den[j]});

      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_x[l][j+1] <= dv_x[l][j] << 1;
          dv_r[l][j+1] <= ge ? DenW'(t - {1'b0, dv_den[j]}) : t[DenW-1:0];
          dv_q[l][j+1] <= {dv_q[l][j][DW-2:0], ge};
        end
      end
    end
  end

  // Round half away from zero, restore sign, saturate.
  localparam logic [DW:0] HiV   = {{(DW + 1 - W){1'b0}}, {(W - 1){1'b1}}};
  localparam logic [DW:0] LoMag = {{(DW + 1 - W){1'b0}}, 1'b1, {(W - 1){1'b0}}};

  logic [W-1:0] comp [0:2];
  logic [W-1:0] root_c;
  logic [DW:0]  root_v;
  rmq_ctl_t     ctl_end;

  assign ctl_end = dv_p[DW][CtlW-1:0];
  assign root_v  = (DW+1)'(dv_h[DW]);
  assign root_c  = (root_v > HiV) ? HiV[W-1:0] : root_v[W-1:0];

  for (genvar l = 0; l < 3; l++) begin : g_fin
    logic          neg;
    logic [DenW:0] r2;
    logic [DW:0]   qr, qn;
    assign neg = dv_p[DW][CtlW + (2 - l) * (W + 1) + W];
    assign r2  = {dv_r[l][DW], 1'b0};
    assign qr  = {1'b0, dv_q[l][DW]} + (DW+1)'(r2 >= {1'b0, dv_den[DW]});
    assign qn  = (DW+1)'(0) - qr;
    always_comb begin
      if (!neg) begin
        comp[l] = (qr > HiV) ? HiV[W-1:0] : qr[W-1:0];
      end else begin
        comp[l] = (qr > LoMag) ? LoMag[W-1:0] : qn[W-1:0];
      end
    end
  end

  logic [W-1:0] qw_d, qx_d, qy_d, qz_d;

  always_comb begin
    case (ctl_end.branch)
      BR_W: begin
        qw_d = root_c;  qx_d = comp[0]; qy_d = comp[1]; qz_d = comp[2];
      end
      BR_Z: begin
        qz_d = root_c;  qw_d = comp[0]; qx_d = comp[1]; qy_d = comp[2];
      end
      BR_Y: begin
        qy_d = root_c;  qw_d = comp[0]; qx_d = comp[1]; qz_d = comp[2];
      end
      default: begin
        qx_d = root_c;  qw_d = comp[0]; qy_d = comp[1]; qz_d = comp[2];
      end
    endcase
    if (ctl_end.bad) begin
      qw_d = '0;
      qx_d = '0;
      qy_d = '0;
      qz_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_o.qw           <= qw_d;
      out_o.qx           <= qx_d;
      out_o.qy           <= qy_d;
      out_o.qz           <= qz_d;
      out_o.root_branch  <= ctl_end.branch;
      out_o.not_rotation <= ctl_end.bad;
    end
  end

  assign out_o.valid = out_v_q;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_o.not_rotation |->
      out_o.qw == '0 && out_o.qx == '0 && out_o.qy == '0 && out_o.qz == '0)
    else $error("flagged result carries nonzero components");
  a_w_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_o.root_branch == BR_W |-> !out_o.not_rotation)
    else $error("trace branch flagged as not a rotation");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && dv_v[DW] |=> dv_v[DW])
    else $error("pipeline tail lost an item during a stall");

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Channel  Dir  Handshake    Payload
// in_i     in   valid/ready  m00..m22, signed Q(W-F).F
// out_o    out  valid/ready  qw qx qy qz, root_branch, not_rotation
//
// One item per cycle sustained while the output is ready. The pipeline is the front register,
// the queue, SW square root stages, (W+1+F) divider stages and the output register;
// SW = (max(W+2, F+1) + F)/2 rounded up, so 49 pipeline stages besides the queue at the defaults.
// The reset clears valid state and queue pointers only. A stall at the output freezes the whole
// back pipeline; the two-entry queue and the front register keep accepting until they are full.
//
// Top level of the rotation matrix to quaternion block.
// Depends on rmq_pkg, rmq_in_if, rmq_out_if, rmq_front, rmq_fifo and rmq_back.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS   = rmq_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = rmq_pkg::VALUE_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o
);
  import rmq_pkg::*;

  localparam int RadW = ((VALUE_WIDTH + 2 > FRAC_BITS + 1) ?
                         VALUE_WIDTH + 2 : FRAC_BITS + 1) + 1;
  localparam int IW   = (RadW - 1) + 3 * (VALUE_WIDTH + 1) + $bits(rmq_ctl_t);

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [IW-1:0] f_item, b_item;

  rmq_front #(.W(VALUE_WIDTH), .F(FRAC_BITS), .IW(IW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  rmq_fifo #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_item)
  );

  rmq_back #(.W(VALUE_WIDTH), .F(FRAC_BITS), .IW(IW)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_i       (b_item),
    .out_o        (out_o)
  );

endmodule
